// File: rtl/kvt_pkg.sv
// Shared constants, operation and status codes, and the controller/datapath
// command and status structs of the key/value table engine.
// No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 64;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_PORT_W  = 64;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 4;
    localparam int SRC_W       = 2;

    localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 4'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_DUMP      = 4'd7;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd8;

    // Source of the result key and value.
    localparam logic [SRC_W-1:0] SRC_REQ   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_ENTRY = 2'd1;
    localparam logic [SRC_W-1:0] SRC_ZERO  = 2'd2;

    typedef struct packed {
        logic                accept;
        logic                scan_step;
        logic                load_out;
        logic [STATUS_W-1:0] out_status;
        logic [SRC_W-1:0]    out_sel;
        logic                out_last;
        logic                wr_update;
        logic                wr_insert;
        logic                save_hole;
        logic                move_rd;
        logic                move_wr;
        logic                clear_count;
    } kvt_cmd_t;

    typedef struct packed {
        logic            hit;
        logic            miss;
        logic            full;
        logic            count_zero;
        logic            rd_vld;
        logic            rd_last;
        logic            out_free;
        logic [OP_W-1:0] op;
    } kvt_stat_t;

endpackage

// File: rtl/key_value_table_engine.sv
// Top level of the key/value table engine: joins the controller and datapath.
// Depends on kvt_pkg, kvt_controller and kvt_datapath.
`timescale 1ns / 1ps
//
// Usage:
// Input transactions (in_valid/in_ready) carry operation, key and value; output
// transactions (out_valid/out_ready) carry status, out_key, out_value and last.
// One request is worked on at a time; in_ready is high while the engine is idle.
// Put, get and delete scan the table from entry 0 with one comparator against a
// single-port read of the key memory, one entry per cycle, for a table of up to
// 32 entries; after a delete the last entry is then moved into the hole, read in
// S_MOVE_RD and written in S_MOVE_WR. Dump reads the entries through a registered
// read and gives one entry per cycle while the receiver takes them, the final one
// with last set; an empty table gives a single empty result.
// Unused operation codes are taken and give no result.
// A result waits in the output register while the receiver stalls; the engine
// may already take the next request, but holds its own scan when its result
// cannot be placed. Reset empties the table; the memories are not cleared,
// since entries at or above the count are never read.

module key_value_table_engine
    import kvt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OP_W-1:0]              operation,
    input  logic signed [KEY_W-1:0]      key,
    input  logic [VAL_PORT_W-1:0]        value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [STATUS_W-1:0]          status,
    output logic signed [KEY_W-1:0]      out_key,
    output logic [VAL_PORT_W-1:0]        out_value,
    output logic                         last
);

    kvt_cmd_t  cmd;
    kvt_stat_t stat;

    kvt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    kvt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .operation (operation),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_key   (out_key),
        .out_value (out_value),
        .last      (last)
    );

endmodule

// File: rtl/kvt_datapath.sv
// Datapath of the key/value table engine: request registers, key and value
// memories, scan pointer with registered read, entry count and output register.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_datapath
    import kvt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  kvt_cmd_t                     cmd,
    output kvt_stat_t                    stat,
    input  logic [OP_W-1:0]              operation,
    input  logic signed [KEY_W-1:0]      key,
    input  logic [VAL_PORT_W-1:0]        value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [STATUS_W-1:0]          status,
    output logic signed [KEY_W-1:0]      out_key,
    output logic [VAL_PORT_W-1:0]        out_value,
    output logic                         last
);

    logic [KEY_W-1:0]       key_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

    logic [OP_W-1:0]        req_op_reg;
    logic [KEY_W-1:0]       req_key_reg;
    logic [VALUE_WIDTH-1:0] req_val_reg;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       addr_reg, addr_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [KEY_W-1:0]       rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic [IDX_W-1:0]       hole_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VAL_PORT_W-1:0]  value_reg;
    logic                   last_reg;

    logic                   scan_rd;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [CNT_W-1:0]       count_m1;
    logic                   wr_key_en;
    logic                   wr_val_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_W-1:0]       wr_key;
    logic [VALUE_WIDTH-1:0] wr_val;
    logic [KEY_W-1:0]       sel_key;
    logic [VAL_PORT_W-1:0]  sel_val;

    assign count_m1 = count_reg - CNT_W'(1);
    assign scan_rd  = cmd.scan_step && (addr_reg < count_reg);
    assign rd_en    = scan_rd || cmd.move_rd;
    assign rd_addr  = cmd.move_rd ? count_m1[IDX_W-1:0] : addr_reg[IDX_W-1:0];

    // Scan pointer: one entry is read per step, compared the cycle after.
    always_comb
    begin
        addr_next   = addr_reg;
        rd_vld_next = rd_vld_reg;
        if (cmd.accept)
        begin
            addr_next   = '0;
            rd_vld_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            rd_vld_next = scan_rd;
            if (scan_rd)
            begin
                addr_next = addr_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.wr_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.move_wr)
        begin
            count_next = count_m1;
        end
    end

    always_comb
    begin
        wr_key_en = cmd.wr_insert || cmd.move_wr;
        wr_val_en = cmd.wr_insert || cmd.move_wr || cmd.wr_update;
        wr_addr   = rd_idx_reg;
        wr_key    = req_key_reg;
        wr_val    = req_val_reg;
        if (cmd.wr_insert)
        begin
            wr_addr = count_reg[IDX_W-1:0];
        end
        else if (cmd.move_wr)
        begin
            wr_addr = hole_reg;
            wr_key  = rd_key_reg;
            wr_val  = rd_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_key_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_val_en)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
        if (cmd.accept)
        begin
            req_op_reg  <= operation;
            req_key_reg <= key;
            req_val_reg <= value[VALUE_WIDTH-1:0];
        end
        if (cmd.save_hole)
        begin
            hole_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register: holds one result until the receiver takes it.
    always_comb
    begin
        unique case (cmd.out_sel)
            SRC_ENTRY:
            begin
                sel_key = rd_key_reg;
                sel_val = VAL_PORT_W'(rd_val_reg);
            end
            SRC_REQ:
            begin
                sel_key = req_key_reg;
                sel_val = '0;
            end
            default:
            begin
                sel_key = '0;
                sel_val = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= cmd.out_status;
            key_reg    <= sel_key;
            value_reg  <= sel_val;
            last_reg   <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_key   = key_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

    assign stat.hit        = rd_vld_reg && (rd_key_reg == req_key_reg);
    assign stat.miss       = !stat.hit && (addr_reg == count_reg);
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.count_zero = (count_reg == '0);
    assign stat.rd_vld     = rd_vld_reg;
    assign stat.rd_last    = (CNT_W'(rd_idx_reg) == count_m1);
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.op         = req_op_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before it was taken");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the table by one");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_insert |-> count_reg < CNT_W'(CAPACITY))
        else $error("insert into a full table");

    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.move_wr || cmd.move_rd) |-> count_reg != '0)
        else $error("delete move on an empty table");
`endif

endmodule

// File: rtl/kvt_controller.sv
// Controller state machine of the key/value table engine: sequences scans,
// inserts, deletes with move of the last entry, clear and dump.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_controller
    import kvt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] operation,
    input  kvt_stat_t       stat,
    output kvt_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_MOVE_RD = 3'd2;
    localparam logic [2:0] S_MOVE_WR = 3'd3;
    localparam logic [2:0] S_CLEAR   = 3'd4;
    localparam logic [2:0] S_DUMP    = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.out_last = 1'b1;
        cmd.out_sel  = SRC_REQ;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (operation) inside
                        OP_PUT, OP_GET, OP_DELETE: state_next = S_SCAN;
                        OP_CLEAR:                  state_next = S_CLEAR;
                        OP_DUMP:                   state_next = S_DUMP;
                        default:                   state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.hit || stat.miss)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                        case (stat.op)
                            OP_PUT:
                            begin
                                if (stat.hit)
                                begin
                                    cmd.out_status = ST_UPDATED;
                                    cmd.wr_update  = 1'b1;
                                end
                                else if (stat.full)
                                begin
                                    cmd.out_status = ST_FULL;
                                end
                                else
                                begin
                                    cmd.out_status = ST_INSERTED;
                                    cmd.wr_insert  = 1'b1;
                                end
                            end
                            OP_GET:
                            begin
                                if (stat.hit)
                                begin
                                    cmd.out_status = ST_FOUND;
                                    cmd.out_sel    = SRC_ENTRY;
                                end
                                else
                                begin
                                    cmd.out_status = ST_NOT_FOUND;
                                end
                            end
                            default:
                            begin
                                if (stat.hit)
                                begin
                                    cmd.out_status = ST_DELETED;
                                    cmd.save_hole  = 1'b1;
                                    state_next     = S_MOVE_RD;
                                end
                                else
                                begin
                                    cmd.out_status = ST_NOT_FOUND;
                                end
                            end
                        endcase
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_CLEAR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out    = 1'b1;
                    cmd.out_status  = ST_CLEARED;
                    cmd.out_sel     = SRC_ZERO;
                    cmd.clear_count = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (stat.count_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_EMPTY;
                        cmd.out_sel    = SRC_ZERO;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // The read of the next entry overlaps the hand-off of this one.
                    cmd.scan_step = !stat.rd_vld || stat.out_free;
                    if (stat.rd_vld && stat.out_free)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_DUMP;
                        cmd.out_sel    = SRC_ENTRY;
                        cmd.out_last   = stat.rd_last;
                        if (stat.rd_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> state_reg == S_IDLE)
        else $error("transaction accepted while busy");

    a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_rd |=> cmd.move_wr)
        else $error("delete move read not followed by its write");

    a_hole_then_move: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.save_hole |=> state_reg == S_MOVE_RD)
        else $error("delete hit did not start the move");
`endif

endmodule

// File: tb/kvt_table_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the key/value table engine. It watches both transaction channels,
// keeps a shadow copy of the table and compares every result against it in order.
// Depends on kvt_pkg.

module kvt_table_checker
    import kvt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [OP_W-1:0]         operation,
    input  logic signed [KEY_W-1:0] key,
    input  logic [VAL_PORT_W-1:0]   value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [STATUS_W-1:0]     status,
    input  logic signed [KEY_W-1:0] out_key,
    input  logic [VAL_PORT_W-1:0]   out_value,
    input  logic                    last,
    output int                      fail_count,
    output int                      outstanding
);

    localparam logic [VAL_PORT_W-1:0] VALUE_MASK =
        {VAL_PORT_W{1'b1}} >> (VAL_PORT_W - VALUE_WIDTH);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [KEY_W-1:0]      key;
        logic [VAL_PORT_W-1:0] value;
        logic                  last;
    } table_result_t;

    table_result_t         pending_results[$];
    table_result_t         oldest;
    logic [KEY_W-1:0]      shadow_keys   [CAPACITY];
    logic [VAL_PORT_W-1:0] shadow_values [CAPACITY];
    int                    entry_total;

    function automatic void push_result(input logic [STATUS_W-1:0] st,
                                        input logic [KEY_W-1:0] k,
                                        input logic [VAL_PORT_W-1:0] v,
                                        input logic fin);
        table_result_t r;
        r.status = st;
        r.key    = k;
        r.value  = v & VALUE_MASK;
        r.last   = fin;
        pending_results.push_back(r);
    endfunction

    // First slot holding the key, or entry_total when it is absent.
    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < entry_total; i++)
        begin
            if (shadow_keys[i] == k)
                return i;
        end
        return entry_total;
    endfunction

    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic [KEY_W-1:0] k,
                                            input logic [VAL_PORT_W-1:0] v);
        int slot;
        logic [VAL_PORT_W-1:0] word;
        slot = find_slot(k);
        word = v & VALUE_MASK;
        case (op)
            OP_PUT:
            begin
                if (slot < entry_total)
                begin
                    shadow_values[slot] = word;
                    push_result(ST_UPDATED, k, '0, 1'b1);
                end
                else if (entry_total >= CAPACITY)
                    push_result(ST_FULL, k, '0, 1'b1);
                else
                begin
                    shadow_keys[entry_total]   = k;
                    shadow_values[entry_total] = word;
                    entry_total++;
                    push_result(ST_INSERTED, k, '0, 1'b1);
                end
            end
            OP_GET:
            begin
                if (slot < entry_total)
                    push_result(ST_FOUND, shadow_keys[slot], shadow_values[slot], 1'b1);
                else
                    push_result(ST_NOT_FOUND, k, '0, 1'b1);
            end
            OP_DELETE:
            begin
                // The last entry fills the hole left by the deleted one.
                if (slot < entry_total)
                begin
                    shadow_keys[slot]   = shadow_keys[entry_total-1];
                    shadow_values[slot] = shadow_values[entry_total-1];
                    entry_total--;
                    push_result(ST_DELETED, k, '0, 1'b1);
                end
                else
                    push_result(ST_NOT_FOUND, k, '0, 1'b1);
            end
            OP_CLEAR:
            begin
                entry_total = 0;
                push_result(ST_CLEARED, '0, '0, 1'b1);
            end
            OP_DUMP:
            begin
                if (entry_total == 0)
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                for (int i = 0; i < entry_total; i++)
                begin
                    push_result(ST_DUMP, shadow_keys[i], shadow_values[i],
                                i == entry_total - 1);
                end
            end
            default:
            begin
                // Unused operation codes are swallowed without a result.
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            entry_total = 0;
            fail_count  = 0;
        end
        else
        begin
            // Results are retired before new requests are predicted, since no
            // result can belong to a request accepted on the same edge.
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: status %0d key %0d value %0h last %0b",
                           status, out_key, out_value, last);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, status);
                        fail_count++;
                    end
                    if (out_key !== oldest.key)
                    begin
                        $error("out_key: expected %0d, actual %0d",
                               $signed(oldest.key), out_key);
                        fail_count++;
                    end
                    if (out_value !== oldest.value)
                    begin
                        $error("out_value: expected %0h, actual %0h",
                               oldest.value, out_value);
                        fail_count++;
                    end
                    if (last !== oldest.last)
                    begin
                        $error("last: expected %0b, actual %0b", oldest.last, last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_request(operation, key, value);
        end
        outstanding = pending_results.size();
    end

endmodule

// File: tb/key_value_table_engine_tb.sv
`timescale 1ns / 1ps
// Testbench top for the key/value table engine: clock, reset, request and
// result-side traffic, and the verdict. Depends on kvt_pkg,
// key_value_table_engine and kvt_table_checker.

module key_value_table_engine_tb;
    import kvt_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key;
    logic [VAL_PORT_W-1:0]   value;
    logic                    out_valid;
    logic                    out_ready;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] out_key;
    logic [VAL_PORT_W-1:0]   out_value;
    logic                    last;
    int                      fail_count;
    int                      outstanding;

    int                      idle_max;
    int                      hold_cycles;
    logic [KEY_W-1:0]        key_pool [64];

    key_value_table_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_key   (out_key),
        .out_value (out_value),
        .last      (last)
    );

    kvt_table_checker u_table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_key     (out_key),
        .out_value   (out_value),
        .last        (last),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [KEY_W-1:0] k,
                                input logic [VAL_PORT_W-1:0] v);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        value     <= v;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int pool_size);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // A run of random requests over a key pool; ignored codes are not counted.
    task automatic run_round(input int pool_size, input int put_pct, input int get_pct,
                             input int del_pct, input int count);
        int done;
        int pick;
        int sub;
        logic [OP_W-1:0] op;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < put_pct)
                op = OP_PUT;
            else if (pick < put_pct + get_pct)
                op = OP_GET;
            else if (pick < put_pct + get_pct + del_pct)
                op = OP_DELETE;
            else
            begin
                sub = $urandom_range(0, 9);
                if (sub < 5)
                    op = OP_DUMP;
                else if (sub < 7)
                    op = OP_CLEAR;
                else
                    op = OP_DUMP + OP_W'($urandom_range(1, 3));
            end
            send_request(op, pick_key(pool_size), {$urandom, $urandom});
            if (op <= OP_DUMP)
                done++;
        end
    endtask

    // Result side: a random stall per result, plus long hold-offs on request.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = $urandom_range(0, idle_max);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_PUT;
        key         = '0;
        value       = '0;
        idle_max    = 10;
        hold_cycles = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 64; i++)
            key_pool[i] = $urandom;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty table, edge keys and values, hole filling on
        // delete, ignored codes, clear.
        send_request(OP_DUMP,   '0, '0);
        send_request(OP_GET,    '0, '0);
        send_request(OP_DELETE, 32'h0000_0005, '1);
        send_request(OP_PUT,    32'h8000_0000, '1);
        send_request(OP_PUT,    32'h7fff_ffff, '0);
        send_request(OP_PUT,    32'h0000_0000, {$urandom, $urandom});
        send_request(OP_PUT,    32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(OP_PUT,    32'h7fff_ffff, 64'h5555_5555_5555_5555);
        send_request(OP_GET,    32'h8000_0000, '0);
        send_request(OP_GET,    32'd12345, '1);
        send_request(OP_DUMP,   '1, '1);
        send_request(OP_DELETE, 32'h8000_0000, '0);
        send_request(OP_DUMP,   '0, '0);
        send_request(OP_DELETE, 32'h0000_0000, '0);
        send_request(OP_GET,    32'h8000_0000, '0);
        send_request(OP_DUMP + 3'd1, '1, '1);
        send_request(OP_DUMP + 3'd2, 32'h1234_5678, {$urandom, $urandom});
        send_request(OP_DUMP + 3'd3, '0, '0);
        send_request(OP_DUMP,   '0, '0);
        send_request(OP_CLEAR,  32'h0bad_cafe, '1);
        send_request(OP_DUMP,   '0, '0);
        send_request(OP_PUT,    32'hffff_ffff, '1);
        send_request(OP_GET,    32'hffff_ffff, '0);

        // The sender waits here until every result is back.
        in_valid <= 1'b0;
        drain_results();

        run_round(6, 40, 30, 20, 28);

        // No idling on either side; more distinct keys than the table holds, so
        // it fills up and the last puts report full.
        idle_max = 0;
        for (int i = 0; i < CAPACITY + 2; i++)
            send_request(OP_PUT, key_pool[i], {$urandom, $urandom});

        // Receiver holds off while dumps and lookups pile up behind the output.
        hold_cycles = 400;
        for (int i = 0; i < 8; i++)
        begin
            if (i % 3 == 0)
                send_request(OP_DUMP, '0, '0);
            else if (i % 3 == 1)
                send_request(OP_GET, pick_key(48), '0);
            else
                send_request(OP_PUT, $urandom, {$urandom, $urandom});
        end
        in_valid <= 1'b0;
        drain_results();
        idle_max = 10;

        run_round(40, 35, 30, 25, 28);
        run_round(3, 30, 30, 30, 20);
        run_round(64, 40, 25, 20, 24);

        in_valid <= 1'b0;
        drain_results();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
